/* rtl/bresenham_line_rasterizer_defines.svh */
// Assertion macros shared by the line rasterizer RTL.
// Needs signals named clk and rst_n in the module that uses them.
`ifndef BRESENHAM_LINE_RASTERIZER_DEFINES_SVH
`define BRESENHAM_LINE_RASTERIZER_DEFINES_SVH

// same-cycle implication, checked outside reset
`define BRL_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("brl: same-cycle check failed");

// next-cycle implication, checked outside reset
`define BRL_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("brl: next-cycle check failed");

`endif

/* rtl/brl_pkg.sv */
// Shared types, codes and pixel packing helpers for the line rasterizer.
// No dependencies; used by brl_engine, brl_pack and the top level.
package brl_pkg;

  // fixed field widths
  localparam int IN_COORD_W = 16;
  localparam int COLOR_W    = 8;
  localparam int ADDR_W     = 26;
  localparam int DATA_W     = 32;
  localparam int BE_W       = 4;
  localparam int WIDTH_W    = 13;
  localparam int STRIDE_W   = 14;
  localparam int FMT_W      = 2;
  localparam int APB_ADDR_W = 4;
  localparam int APB_DATA_W = 32;

  // transaction kinds
  localparam logic FUNC_START = 1'b0;
  localparam logic FUNC_TICK  = 1'b1;

  // pixel formats
  localparam logic [FMT_W-1:0] FMT_RGB565 = 2'd0;
  localparam logic [FMT_W-1:0] FMT_BGR    = 2'd1;
  localparam logic [FMT_W-1:0] FMT_BGRX   = 2'd2;

  // byte enables per format
  localparam logic [BE_W-1:0] BE_RGB565 = 4'b0011;
  localparam logic [BE_W-1:0] BE_BGR    = 4'b0111;
  localparam logic [BE_W-1:0] BE_BGRX   = 4'b1111;

  // register indexes
  localparam logic [1:0] REG_SCREEN_WIDTH  = 2'd0;
  localparam logic [1:0] REG_SCREEN_HEIGHT = 2'd1;
  localparam logic [1:0] REG_ROW_STRIDE    = 2'd2;
  localparam logic [1:0] REG_PIXEL_FORMAT  = 2'd3;

  // register reset values
  localparam logic [WIDTH_W-1:0]  RST_SCREEN_WIDTH  = 13'd640;
  localparam logic [WIDTH_W-1:0]  RST_SCREEN_HEIGHT = 13'd480;
  localparam logic [STRIDE_W-1:0] RST_ROW_STRIDE    = 14'd2560;
  localparam logic [FMT_W-1:0]    RST_PIXEL_FORMAT  = FMT_BGRX;

  typedef struct packed {
    logic [WIDTH_W-1:0]  screen_width;
    logic [WIDTH_W-1:0]  screen_height;
    logic [STRIDE_W-1:0] row_stride;
    logic [FMT_W-1:0]    pixel_format;
  } cfg_t;

  // one rasterized point on its way to the packer
  typedef struct packed {
    logic                 valid;
    logic                 last;
    logic [3*COLOR_W-1:0] color;  // red, green, blue from msb down
  } point_info_t;

  // column times bytes per pixel
  function automatic logic [WIDTH_W+1:0] col_offset(input logic [FMT_W-1:0] fmt,
                                                    input logic [WIDTH_W-1:0] col);
    logic [WIDTH_W+1:0] col2;
    col2 = {1'b0, col, 1'b0};
    unique case (fmt)
      FMT_RGB565: col_offset = col2;
      FMT_BGR:    col_offset = col2 + (WIDTH_W+2)'(col);
      default:    col_offset = {col, 2'b00};
    endcase
  endfunction

  // packed pixel, blue in the lowest byte
  function automatic logic [DATA_W-1:0] pack_data(input logic [FMT_W-1:0] fmt,
                                                  input logic [3*COLOR_W-1:0] color);
    logic [COLOR_W-1:0] r, g, b;
    r = color[23:16];
    g = color[15:8];
    b = color[7:0];
    unique case (fmt)
      FMT_RGB565: pack_data = {16'h0000, r[7:3], g[7:2], b[7:3]};
      default:    pack_data = {8'h00, r, g, b};
    endcase
  endfunction

  function automatic logic [BE_W-1:0] byte_en(input logic [FMT_W-1:0] fmt);
    unique case (fmt)
      FMT_RGB565: byte_en = BE_RGB565;
      FMT_BGR:    byte_en = BE_BGR;
      default:    byte_en = BE_BGRX;
    endcase
  endfunction

endpackage

/* rtl/bresenham_line_rasterizer.sv */
// Top level of the Bresenham line rasterizer: config registers and pipeline control.
// Depends on brl_pkg, brl_engine and brl_pack.

// Takes one transaction per clock and gives one pixel write per clock unless
// out_stall holds a waiting result. A start transaction sets up a line and
// yields its first point; each tick after it yields the next point until the
// one marked last_point, after which ticks yield nothing until the next
// start. A result is registered after the Bresenham step and again after
// the clip, address multiply and pixel packing. in_stall follows out_stall
// while a result is waiting. Configuration writes belong in idle periods.
module bresenham_line_rasterizer #(
  parameter int COORD_BITS = 16
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // input channel
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic                                  in_func,
  input  logic signed [brl_pkg::IN_COORD_W-1:0] in_x_start,
  input  logic signed [brl_pkg::IN_COORD_W-1:0] in_y_start,
  input  logic signed [brl_pkg::IN_COORD_W-1:0] in_x_end,
  input  logic signed [brl_pkg::IN_COORD_W-1:0] in_y_end,
  input  logic [brl_pkg::COLOR_W-1:0]           in_red,
  input  logic [brl_pkg::COLOR_W-1:0]           in_green,
  input  logic [brl_pkg::COLOR_W-1:0]           in_blue,
  // result channel
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic                                  out_write_enable,
  output logic [brl_pkg::ADDR_W-1:0]            out_byte_address,
  output logic [brl_pkg::DATA_W-1:0]            out_write_data,
  output logic [brl_pkg::BE_W-1:0]              out_byte_enables,
  output logic                                  out_last_point,
  // configuration port
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [brl_pkg::APB_ADDR_W-1:0]        paddr,
  input  logic [brl_pkg::APB_DATA_W-1:0]        pwdata,
  output logic [brl_pkg::APB_DATA_W-1:0]        prdata,
  output logic                                  pready
);
  import brl_pkg::*;

  cfg_t                         cfg_r;
  logic                         cfg_wr;
  logic [1:0]                   reg_idx;
  logic                         adv, in_take;
  point_info_t                  pt;
  logic signed [COORD_BITS-1:0] pt_col, pt_row;

  // register file
  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.screen_width  <= RST_SCREEN_WIDTH;
      cfg_r.screen_height <= RST_SCREEN_HEIGHT;
      cfg_r.row_stride    <= RST_ROW_STRIDE;
      cfg_r.pixel_format  <= RST_PIXEL_FORMAT;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_SCREEN_WIDTH:  cfg_r.screen_width  <= pwdata[WIDTH_W-1:0];
        REG_SCREEN_HEIGHT: cfg_r.screen_height <= pwdata[WIDTH_W-1:0];
        REG_ROW_STRIDE:    cfg_r.row_stride    <= pwdata[STRIDE_W-1:0];
        REG_PIXEL_FORMAT:  cfg_r.pixel_format  <= pwdata[FMT_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_SCREEN_WIDTH:  prdata = APB_DATA_W'(cfg_r.screen_width);
      REG_SCREEN_HEIGHT: prdata = APB_DATA_W'(cfg_r.screen_height);
      REG_ROW_STRIDE:    prdata = APB_DATA_W'(cfg_r.row_stride);
      REG_PIXEL_FORMAT:  prdata = APB_DATA_W'(cfg_r.pixel_format);
    endcase
  end

  // whole pipeline moves unless a finished result is held
  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;
  assign in_take  = in_valid && adv;

  brl_engine #(
    .COORD_BITS(COORD_BITS)
  ) u_engine (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .in_take (in_take),
    .func    (in_func),
    .x_start (in_x_start),
    .y_start (in_y_start),
    .x_end   (in_x_end),
    .y_end   (in_y_end),
    .red     (in_red),
    .green   (in_green),
    .blue    (in_blue),
    .pt      (pt),
    .pt_col  (pt_col),
    .pt_row  (pt_row)
  );

  brl_pack #(
    .COORD_BITS(COORD_BITS)
  ) u_pack (
    .clk              (clk),
    .rst_n            (rst_n),
    .adv              (adv),
    .cfg              (cfg_r),
    .pt               (pt),
    .pt_col           (pt_col),
    .pt_row           (pt_row),
    .out_valid        (out_valid),
    .out_write_enable (out_write_enable),
    .out_byte_address (out_byte_address),
    .out_write_data   (out_write_data),
    .out_byte_enables (out_byte_enables),
    .out_last_point   (out_last_point)
  );

endmodule

/* rtl/brl_engine.sv */
// Bresenham stepping engine: line setup on start, one step per tick.
// Depends on brl_pkg and bresenham_line_rasterizer_defines.svh.
`include "bresenham_line_rasterizer_defines.svh"

module brl_engine #(
  parameter int COORD_BITS = 16
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    adv,      // pipeline moves
  input  logic                                    in_take,  // transaction accepted
  input  logic                                    func,
  input  logic signed [brl_pkg::IN_COORD_W-1:0]   x_start,
  input  logic signed [brl_pkg::IN_COORD_W-1:0]   y_start,
  input  logic signed [brl_pkg::IN_COORD_W-1:0]   x_end,
  input  logic signed [brl_pkg::IN_COORD_W-1:0]   y_end,
  input  logic [brl_pkg::COLOR_W-1:0]             red,
  input  logic [brl_pkg::COLOR_W-1:0]             green,
  input  logic [brl_pkg::COLOR_W-1:0]             blue,
  output brl_pkg::point_info_t                    pt,
  output logic signed [COORD_BITS-1:0]            pt_col,
  output logic signed [COORD_BITS-1:0]            pt_row
);
  import brl_pkg::*;

  localparam int CW  = COORD_BITS;
  localparam int DW  = COORD_BITS + 1;  // deltas
  localparam int EW  = COORD_BITS + 3;  // error term
  localparam int E2W = COORD_BITS + 4;  // doubled error term

  // line state
  logic signed [CW-1:0]  cur_col_r, cur_row_r, end_col_r, end_row_r;
  logic signed [CW-1:0]  cur_col_nxt, cur_row_nxt, end_col_nxt, end_row_nxt;
  logic [DW-1:0]         delta_col_r, delta_row_r, delta_col_nxt, delta_row_nxt;
  logic                  step_left_r, step_up_r, step_left_nxt, step_up_nxt;
  logic signed [EW-1:0]  err_r, err_nxt;
  logic [3*COLOR_W-1:0]  color_r, color_nxt;
  logic                  busy_r, busy_nxt;

  // point register toward the packer
  point_info_t           pt_nxt;
  logic                  pt_valid_r, pt_last_r;
  logic [3*COLOR_W-1:0]  pt_color_r;
  logic signed [CW-1:0]  pt_col_r, pt_row_r;

  logic                  start_c, tick_c, last_c;
  logic signed [CW-1:0]  sc, sr, ec, er;
  logic signed [DW-1:0]  dcol_diff, drow_diff;
  logic [DW-1:0]         dcol_abs, drow_abs;
  logic signed [E2W-1:0] e2, dcol_x, drow_x;
  logic signed [EW-1:0]  dcol_e, drow_e;
  logic                  mv_col, mv_row;

  assign start_c = in_take && (func == FUNC_START);
  assign tick_c  = in_take && (func == FUNC_TICK) && busy_r;

  // endpoints wrapped or extended to the coordinate width
  assign sc = CW'(x_start);
  assign sr = CW'(y_start);
  assign ec = CW'(x_end);
  assign er = CW'(y_end);

  // setup: absolute deltas
  assign dcol_diff = DW'(ec) - DW'(sc);
  assign drow_diff = DW'(er) - DW'(sr);
  assign dcol_abs  = dcol_diff[DW-1] ? $unsigned(-dcol_diff) : $unsigned(dcol_diff);
  assign drow_abs  = drow_diff[DW-1] ? $unsigned(-drow_diff) : $unsigned(drow_diff);

  // step decision from the stored error term
  assign dcol_e = EW'($signed({1'b0, delta_col_r}));
  assign drow_e = EW'($signed({1'b0, delta_row_r}));
  assign dcol_x = E2W'($signed({1'b0, delta_col_r}));
  assign drow_x = E2W'($signed({1'b0, delta_row_r}));
  assign e2     = E2W'(err_r) <<< 1;
  assign mv_col = e2 > -drow_x;
  assign mv_row = e2 < dcol_x;

  always_comb begin
    cur_col_nxt   = cur_col_r;
    cur_row_nxt   = cur_row_r;
    end_col_nxt   = end_col_r;
    end_row_nxt   = end_row_r;
    delta_col_nxt = delta_col_r;
    delta_row_nxt = delta_row_r;
    step_left_nxt = step_left_r;
    step_up_nxt   = step_up_r;
    err_nxt       = err_r;
    color_nxt     = color_r;
    if (start_c) begin
      cur_col_nxt   = sc;
      cur_row_nxt   = sr;
      end_col_nxt   = ec;
      end_row_nxt   = er;
      delta_col_nxt = dcol_abs;
      delta_row_nxt = drow_abs;
      step_left_nxt = !(sc < ec);
      step_up_nxt   = !(sr < er);
      err_nxt       = EW'($signed({1'b0, dcol_abs})) - EW'($signed({1'b0, drow_abs}));
      color_nxt     = {red, green, blue};
    end else if (tick_c) begin
      err_nxt = err_r - (mv_col ? drow_e : '0) + (mv_row ? dcol_e : '0);
      if (mv_col) begin
        cur_col_nxt = step_left_r ? cur_col_r - CW'(1) : cur_col_r + CW'(1);
      end
      if (mv_row) begin
        cur_row_nxt = step_up_r ? cur_row_r - CW'(1) : cur_row_r + CW'(1);
      end
    end
    last_c   = (cur_col_nxt == end_col_nxt) && (cur_row_nxt == end_row_nxt);
    busy_nxt = (start_c || tick_c) ? !last_c : busy_r;
    pt_nxt.valid = start_c || tick_c;
    pt_nxt.last  = last_c;
    pt_nxt.color = color_nxt;
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_col_r   <= '0;
      cur_row_r   <= '0;
      end_col_r   <= '0;
      end_row_r   <= '0;
      delta_col_r <= '0;
      delta_row_r <= '0;
      step_left_r <= 1'b0;
      step_up_r   <= 1'b0;
      err_r       <= '0;
      color_r     <= '0;
      busy_r      <= 1'b0;
      pt_valid_r  <= 1'b0;
    end else begin
      cur_col_r   <= cur_col_nxt;
      cur_row_r   <= cur_row_nxt;
      end_col_r   <= end_col_nxt;
      end_row_r   <= end_row_nxt;
      delta_col_r <= delta_col_nxt;
      delta_row_r <= delta_row_nxt;
      step_left_r <= step_left_nxt;
      step_up_r   <= step_up_nxt;
      err_r       <= err_nxt;
      color_r     <= color_nxt;
      busy_r      <= busy_nxt;
      if (adv) begin
        pt_valid_r <= pt_nxt.valid;
      end
    end
  end

  // point payload
  always_ff @(posedge clk) begin
    if (adv) begin
      pt_last_r  <= pt_nxt.last;
      pt_color_r <= pt_nxt.color;
      pt_col_r   <= cur_col_nxt;
      pt_row_r   <= cur_row_nxt;
    end
  end

  assign pt     = {pt_valid_r, pt_last_r, pt_color_r};
  assign pt_col = pt_col_r;
  assign pt_row = pt_row_r;

  `BRL_ASSERT_NXT(a_idle_tick_no_point, in_take && (func == FUNC_TICK) && !busy_r, !pt_valid_r)
  `BRL_ASSERT_NXT(a_start_gives_point, in_take && (func == FUNC_START), pt_valid_r)
  `BRL_ASSERT_IMP(a_last_point_idles, pt_valid_r && pt_last_r, !busy_r)

endmodule

/* rtl/brl_pack.sv */
// Clipping, byte address and pixel packing, with the result register.
// Depends on brl_pkg and bresenham_line_rasterizer_defines.svh.
`include "bresenham_line_rasterizer_defines.svh"

module brl_pack #(
  parameter int COORD_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          adv,
  input  brl_pkg::cfg_t                 cfg,
  input  brl_pkg::point_info_t          pt,
  input  logic signed [COORD_BITS-1:0]  pt_col,
  input  logic signed [COORD_BITS-1:0]  pt_row,
  output logic                          out_valid,
  output logic                          out_write_enable,
  output logic [brl_pkg::ADDR_W-1:0]    out_byte_address,
  output logic [brl_pkg::DATA_W-1:0]    out_write_data,
  output logic [brl_pkg::BE_W-1:0]      out_byte_enables,
  output logic                          out_last_point
);
  import brl_pkg::*;

  localparam int CMP_W = COORD_BITS + WIDTH_W;
  localparam int ROW_W = WIDTH_W + STRIDE_W;

  logic                 on_c;
  logic [WIDTH_W-1:0]   col_u, row_u;
  logic [ROW_W-1:0]     row_off;
  logic [WIDTH_W+1:0]   col_off;
  logic [ADDR_W-1:0]    addr_c;

  logic                 valid_r;
  logic                 we_r, last_r;
  logic [ADDR_W-1:0]    addr_r;
  logic [DATA_W-1:0]    data_r;
  logic [BE_W-1:0]      be_r;
  logic                 be_legal;

  // clip against the screen
  assign on_c = !pt_col[COORD_BITS-1] && !pt_row[COORD_BITS-1] &&
                (CMP_W'($unsigned(pt_col)) < CMP_W'(cfg.screen_width)) &&
                (CMP_W'($unsigned(pt_row)) < CMP_W'(cfg.screen_height));

  // on screen both coordinates are below 2^13
  assign col_u   = WIDTH_W'($unsigned(pt_col));
  assign row_u   = WIDTH_W'($unsigned(pt_row));
  assign row_off = ROW_W'(row_u) * ROW_W'(cfg.row_stride);
  assign col_off = col_offset(cfg.pixel_format, col_u);
  assign addr_c  = ADDR_W'(row_off) + ADDR_W'(col_off);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= pt.valid;
    end
  end

  // result payload, zeroed when clipped
  always_ff @(posedge clk) begin
    if (adv) begin
      we_r   <= on_c;
      last_r <= pt.last;
      addr_r <= on_c ? addr_c : '0;
      data_r <= on_c ? pack_data(cfg.pixel_format, pt.color) : '0;
      be_r   <= on_c ? byte_en(cfg.pixel_format) : '0;
    end
  end

  assign out_valid        = valid_r;
  assign out_write_enable = we_r;
  assign out_byte_address = addr_r;
  assign out_write_data   = data_r;
  assign out_byte_enables = be_r;
  assign out_last_point   = last_r;

  assign be_legal = (be_r == BE_RGB565) || (be_r == BE_BGR) || (be_r == BE_BGRX);

  `BRL_ASSERT_IMP(a_clipped_zero, valid_r && !we_r, (addr_r == '0) && (data_r == '0) && (be_r == '0))
  `BRL_ASSERT_IMP(a_enables_legal, valid_r && we_r, be_legal)
  `BRL_ASSERT_NXT(a_hold_on_stall, valid_r && !adv, valid_r)

endmodule
